>>> sv/mkpq_pkg.sv
// Package: record, cell, control and channel types for the min-key priority queue.
`default_nettype none
package mkpq_pkg;

   // Number of record cells in the sorted chain
   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int FILL_W      = 5;

   // Request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;  // no-op

   // Status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // One stored record
   typedef struct packed {
      logic [31:0] tag;
      logic [31:0] grade;
      logic [11:0] hours;
      logic [11:0] year;
   } mkpq_rec_type;

   // Contents of one cell
   typedef struct packed {
      logic         valid;
      mkpq_rec_type rec;
   } mkpq_cell_type;

   // Chain-wide operation for this cycle
   typedef struct packed {
      logic insert;
      logic remove;
      logic clear;
   } mkpq_ctl_type;

   // Request transaction payload
   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] record_tag;
      logic [31:0] grade_bits;
      logic [11:0] workload_hours;
      logic [11:0] entry_year;
   } mkpq_req_type;

   // Response transaction payload
   typedef struct packed {
      logic [1:0]        status;
      logic [31:0]       out_tag;
      logic [31:0]       out_grade_bits;
      logic [11:0]       out_hours;
      logic [11:0]       out_year;
      logic [FILL_W-1:0] fill_level;
   } mkpq_rsp_type;

endpackage
`default_nettype wire

>>> sv/min_key_priority_queue_unit.sv
// Top level: min-key priority queue built as a sorted chain of record cells.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_data  (mkpq_req_type)
//   rsp      out        rsp_valid/rsp_ready  rsp_data  (mkpq_rsp_type)
//
// One transaction per cycle while req_ready is high: every request is resolved in
// the cycle it is accepted, since the chain keeps records sorted by year, head first.
// The response is captured in an output register on acceptance.
// req_ready is low only while a response waits and rsp_ready is low.
// Synchronous reset empties the chain by clearing the cell valid bits.
`default_nettype none
module min_key_priority_queue_unit (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire mkpq_pkg::mkpq_req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output mkpq_pkg::mkpq_rsp_type rsp_data
);
   import mkpq_pkg::*;

   logic          accept;
   mkpq_ctl_type  ctl;
   mkpq_rec_type  new_rec;
   mkpq_cell_type cell_q    [QUEUE_DEPTH];
   logic          gt_q      [QUEUE_DEPTH];
   mkpq_cell_type prev_cell [QUEUE_DEPTH];
   logic          prev_gt   [QUEUE_DEPTH];
   mkpq_cell_type next_cell [QUEUE_DEPTH];
   logic          empty, full;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   mkpq_rsp_type  rsp_data_ff, rsp_data_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign empty     = !cell_q[0].valid;
   assign full      = cell_q[QUEUE_DEPTH-1].valid;
   assign new_rec   = '{tag: req_data.record_tag, grade: req_data.grade_bits,
                        hours: req_data.workload_hours, year: req_data.entry_year};

   // Chain operation for this cycle
   always_comb begin
      ctl.insert = accept && (req_data.req_type == REQ_INSERT) && !full;
      ctl.remove = accept && (req_data.req_type == REQ_REMOVE) && !empty;
      ctl.clear  = accept && (req_data.req_type == REQ_CLEAR)  && !empty;
   end

   // Neighbor wiring; the head sees no smaller entry ahead, the tail an empty one behind
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (i == 0) begin
            prev_cell[i] = '{valid: 1'b1, rec: new_rec};
            prev_gt[i]   = 1'b0;
         end else begin
            prev_cell[i] = cell_q[i-1];
            prev_gt[i]   = gt_q[i-1];
         end
         if (i == QUEUE_DEPTH - 1) begin
            next_cell[i] = '{valid: 1'b0, rec: new_rec};
         end else begin
            next_cell[i] = cell_q[i+1];
         end
      end
   end

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      mkpq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .new_rec   (new_rec),
         .prev_cell (prev_cell[g]),
         .prev_gt   (prev_gt[g]),
         .next_cell (next_cell[g]),
         .this_cell (cell_q[g]),
         .gt        (gt_q[g])
      );
   end

   // Record count and response
   always_comb begin
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (ctl.insert) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (ctl.remove) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end else if (ctl.clear) begin
         cnt_in = '0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         case (req_data.req_type)
            REQ_INSERT: rsp_data_in.status = full ? ST_FULL : ST_DONE;
            REQ_REMOVE: begin
               rsp_data_in.status = empty ? ST_EMPTY : ST_DONE;
               if (!empty) begin
                  rsp_data_in.out_tag        = cell_q[0].rec.tag;
                  rsp_data_in.out_grade_bits = cell_q[0].rec.grade;
                  rsp_data_in.out_hours      = cell_q[0].rec.hours;
                  rsp_data_in.out_year       = cell_q[0].rec.year;
               end
            end
            REQ_CLEAR:  rsp_data_in.status = empty ? ST_EMPTY : ST_DONE;
            default:    rsp_data_in.status = ST_DONE;
         endcase
         rsp_data_in.fill_level = FILL_W'(cnt_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // Head cell occupancy tracks the count
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) == cell_q[0].valid)
      else $error("head valid disagrees with record count");

   // Head holds the smallest year of the first two records
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_q[1].valid |-> (cell_q[0].rec.year <= cell_q[1].rec.year))
      else $error("chain head out of order");

   // Insert into a full chain is refused
   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.req_type == REQ_INSERT && full)
      |=> (rsp_data.status == ST_FULL) && (cnt_ff == $past(cnt_ff)))
      else $error("insert on full queue not refused");

   // A remove from a non-empty chain drops the count by one
   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      ctl.remove |=> (cnt_ff == $past(cnt_ff) - CNT_W'(1)))
      else $error("remove did not decrement count");
`endif

endmodule
`default_nettype wire

>>> sv/mkpq_cell.sv
// One cell of the sorted record chain: holds a record and trades it with its neighbors.
`default_nettype none
module mkpq_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  wire mkpq_pkg::mkpq_ctl_type  ctl,
   input  wire mkpq_pkg::mkpq_rec_type  new_rec,
   input  wire mkpq_pkg::mkpq_cell_type prev_cell,
   input  wire                    prev_gt,
   input  wire mkpq_pkg::mkpq_cell_type next_cell,
   output mkpq_pkg::mkpq_cell_type this_cell,
   output logic                   gt
);
   import mkpq_pkg::*;

   logic         valid_ff, valid_in;
   mkpq_rec_type rec_ff, rec_in;

   // New record sorts before this one (empty cells always yield)
   assign gt        = !valid_ff || (rec_ff.year > new_rec.year);
   assign this_cell = '{valid: valid_ff, rec: rec_ff};

   // Next cell contents
   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.remove) begin
         valid_in = next_cell.valid;
         rec_in   = next_cell.rec;
      end else if (ctl.insert && gt) begin
         if (prev_gt) begin
            valid_in = prev_cell.valid;
            rec_in   = prev_cell.rec;
         end else begin
            valid_in = 1'b1;
            rec_in   = new_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for the min-key priority queue: directed and random requests checked against a predictor.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mkpq_pkg::*;

   localparam int unsigned LONG_HOLD   = 300;     // receiver hold-off, cycles
   localparam int unsigned TAIL_CYCLES = 20;      // quiet cycles after the last response
   localparam int unsigned TIMEOUT_NS  = 1000000; // timeout for the whole run
   localparam int unsigned PRINT_CAP   = 200;

   typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   mkpq_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   mkpq_rsp_type rsp_data;

   // Predictor state: records in arrival order
   mkpq_rec_type held_records[$];
   // Expected responses, oldest first
   mkpq_rsp_type pending_rsp[$];

   int unsigned mismatch_count = 0;

   // Sender pacing
   int unsigned burst_left = 0;
   int unsigned max_gap    = 4;
   int unsigned max_burst  = 12;

   // Receiver control, written only by the test sequence
   sink_mode_type sink_mode  = SINK_OPEN;
   int unsigned   hold_count = 0;

   min_key_priority_queue_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("min_key_priority_queue_unit: mismatch");
      $finish;
   end

   // One line per mismatch, capped so a broken run stays readable
   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP)
         $display("%0t ERROR: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   // Next response of the queue for one request; updates the held records
   function automatic mkpq_rsp_type queue_response(input mkpq_req_type r);
      mkpq_rsp_type rsp;
      mkpq_rec_type rec;
      int           best;
      rsp = '0;
      rsp.status = ST_DONE;
      case (r.req_type)
         REQ_INSERT: begin
            if (held_records.size() >= QUEUE_DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               rec.tag   = r.record_tag;
               rec.grade = r.grade_bits;
               rec.hours = r.workload_hours;
               rec.year  = r.entry_year;
               held_records.push_back(rec);
            end
         end
         REQ_REMOVE: begin
            if (held_records.size() == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               // smallest year; strict compare keeps the earliest on ties
               best = 0;
               for (int i = 1; i < held_records.size(); i++)
                  if (held_records[i].year < held_records[best].year)
                     best = i;
               rsp.out_tag        = held_records[best].tag;
               rsp.out_grade_bits = held_records[best].grade;
               rsp.out_hours      = held_records[best].hours;
               rsp.out_year       = held_records[best].year;
               held_records.delete(best);
            end
         end
         REQ_CLEAR: begin
            if (held_records.size() == 0)
               rsp.status = ST_EMPTY;
            else
               held_records.delete();
         end
         default: ; // unused code: no-op
      endcase
      rsp.fill_level = FILL_W'(held_records.size());
      return rsp;
   endfunction

   // Predict on request transactions, check response transactions
   always @(posedge clock) begin : rsp_check
      mkpq_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("response with none expected");
            end else begin
               want = pending_rsp.pop_front();
               check_field("status", 32'(rsp_data.status), 32'(want.status));
               check_field("out_tag", rsp_data.out_tag, want.out_tag);
               check_field("out_grade_bits", rsp_data.out_grade_bits, want.out_grade_bits);
               check_field("out_hours", 32'(rsp_data.out_hours), 32'(want.out_hours));
               check_field("out_year", 32'(rsp_data.out_year), 32'(want.out_year));
               check_field("fill_level", 32'(rsp_data.fill_level), 32'(want.fill_level));
            end
         end
         if (req_valid && req_ready)
            pending_rsp.push_back(queue_response(req_data));
      end
   end

   // Receiver: long hold-off on request, otherwise the selected stall mode
   initial begin : rsp_sink
      int unsigned hold_seen;
      int unsigned hold_left;
      int unsigned beat;
      hold_seen = 0;
      hold_left = 0;
      beat      = 0;
      forever begin
         @(negedge clock);
         if (hold_count != hold_seen) begin
            hold_seen = hold_count;
            hold_left = LONG_HOLD;
         end
         beat++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (sink_mode)
               SINK_OPEN:   rsp_ready <= 1'b1;
               SINK_RANDOM: rsp_ready <= ($urandom_range(0, 99) >= 35);
               default:     rsp_ready <= ((beat % 7) < 3) || ((beat % 11) == 5);
            endcase
         end
      end
   end

   // Send one request transaction; returns at the falling edge after acceptance
   task automatic send_req(input mkpq_req_type item);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, max_gap)) @(negedge clock);
         burst_left = $urandom_range(1, max_burst);
      end
      burst_left--;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stop sending until every expected response has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
   endtask

   function automatic mkpq_req_type make_req(input logic [1:0] kind, input logic [31:0] tag,
                                             input logic [31:0] grade,
                                             input logic [11:0] hours,
                                             input logic [11:0] year);
      mkpq_req_type r;
      r.req_type       = kind;
      r.record_tag     = tag;
      r.grade_bits     = grade;
      r.workload_hours = hours;
      r.entry_year     = year;
      return r;
   endfunction

   // Random payload; narrow years make ties common
   function automatic mkpq_req_type random_req(input logic [1:0] kind, input bit narrow);
      logic [11:0] year;
      case ($urandom_range(0, 9))
         0:       year = 12'd0;
         1:       year = 12'hFFF;
         default: year = narrow ? 12'($urandom_range(0, 7)) : 12'($urandom_range(0, 4095));
      endcase
      return make_req(kind, $urandom, $urandom, 12'($urandom_range(0, 4095)), year);
   endfunction

   // Remove and clear on an empty queue, unused code on an empty queue
   task automatic test_empty_queue();
      sink_mode = SINK_RANDOM;
      send_req(random_req(REQ_REMOVE, 1'b0));
      send_req(random_req(REQ_CLEAR, 1'b0));
      send_req(random_req(REQ_UNUSED, 1'b0));
      wait_drained();
   endtask

   // Fill to capacity with field extremes and year ties, refuse one more,
   // then remove in priority order
   task automatic test_full_queue();
      logic [11:0] years[14] = '{12'd7, 12'd3, 12'd7, 12'd0, 12'hFFF, 12'd3, 12'd9,
                                12'd3, 12'd100, 12'd7, 12'd0, 12'd2048, 12'd1, 12'd3};
      sink_mode = SINK_PATTERN;
      send_req(make_req(REQ_INSERT, 32'h0, 32'h0, 12'h0, 12'h0));
      send_req(make_req(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF));
      foreach (years[i])
         send_req(make_req(REQ_INSERT, $urandom, $urandom, 12'($urandom_range(0, 4095)),
                           years[i]));
      send_req(random_req(REQ_INSERT, 1'b0));
      repeat (4) send_req(random_req(REQ_REMOVE, 1'b0));
      wait_drained();
   endtask

   // Clear a non-empty queue, then the unused code with busy fields
   task automatic test_clear_and_unused();
      sink_mode = SINK_OPEN;
      send_req(random_req(REQ_CLEAR, 1'b0));
      send_req(random_req(REQ_INSERT, 1'b1));
      send_req(make_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF));
      send_req(random_req(REQ_REMOVE, 1'b1));
      wait_drained();
   endtask

   // Receiver holds off for a long stretch while requests keep coming
   task automatic test_output_hold();
      sink_mode  = SINK_OPEN;
      burst_left = 64;
      hold_count++;
      repeat (16) send_req(random_req(REQ_INSERT, 1'b1));
      repeat (8) send_req(random_req(REQ_REMOVE, 1'b1));
      wait_drained();
   endtask

   // Random mix in phases; insert share varies so the queue swings
   // between empty and full
   task automatic test_random_traffic(input int unsigned n_items);
      int unsigned insert_pct;
      int unsigned roll;
      bit          narrow;
      insert_pct = 50;
      narrow     = 1'b1;
      for (int i = 0; i < n_items; i++) begin
         if (i % 100 == 0) begin
            case ($urandom_range(0, 2))
               0:       insert_pct = 85;
               1:       insert_pct = 50;
               default: insert_pct = 20;
            endcase
            narrow    = $urandom_range(0, 3) != 0;
            sink_mode = sink_mode_type'($urandom_range(0, 2));
            max_gap   = $urandom_range(1, 6);
            max_burst = ($urandom_range(0, 3) == 0) ? 40 : 10;
         end
         if (i % 300 == 150)
            wait_drained();
         roll = $urandom_range(0, 99);
         if (roll < 2)
            send_req(random_req(REQ_CLEAR, narrow));
         else if (roll < 3)
            send_req(random_req(REQ_UNUSED, narrow));
         else if (roll < 3 + insert_pct)
            send_req(random_req(REQ_INSERT, narrow));
         else
            send_req(random_req(REQ_REMOVE, narrow));
      end
      wait_drained();
   endtask

   initial begin : run_tests
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_queue();
      test_full_queue();
      test_clear_and_unused();
      test_output_hold();
      test_random_traffic(1360);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("min_key_priority_queue_unit: match");
      else
         $display("min_key_priority_queue_unit: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
